// File: sv/pulse_width_rf_code_sender_defines.svh
// Assertion macros for the pulse-width RF code sender.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef PULSE_WIDTH_RF_CODE_SENDER_DEFINES_SVH
`define PULSE_WIDTH_RF_CODE_SENDER_DEFINES_SVH

`ifndef SYNTHESIS
`define PWRF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PWRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PWRF_ASSERT_IMPL(label, ante, cons, msg)
`define PWRF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/pwrf_pkg.sv
// Package for the pulse-width RF code sender: widths, codes, reset values, types.
// No dependencies.
`timescale 1ns / 1ps

package pwrf_pkg;

    localparam int CODE_BITS   = 24;
    localparam int BIT_IDX_W   = $clog2(CODE_BITS);
    localparam int PULSE_W     = 16;
    localparam int GAP_W       = 20;
    localparam int REP_W       = 4;
    localparam int TIMER_W     = 20;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 20;

    localparam logic [PULSE_W-1:0] SHORT_RESET  = PULSE_W'(300);
    localparam logic [PULSE_W-1:0] LONG_RESET   = PULSE_W'(900);
    localparam logic [GAP_W-1:0]   GAP_RESET    = GAP_W'(10000);
    localparam logic [REP_W-1:0]   REPEAT_RESET = REP_W'(6);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT  = 4'd0,
        REG_LONG   = 4'd1,
        REG_GAP    = 4'd2,
        REG_REPEAT = 4'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_HIGH = 3'd1,
        PH_START_LOW  = 3'd2,
        PH_BIT_HIGH   = 3'd3,
        PH_BIT_LOW    = 3'd4,
        PH_GAP        = 3'd5
    } phase_t;

    typedef struct packed {
        logic [PULSE_W-1:0] short_ticks;
        logic [PULSE_W-1:0] long_ticks;
        logic [GAP_W-1:0]   gap_ticks;
        logic [REP_W-1:0]   repeat_count;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic done_res;
    } res_t;

    typedef struct packed {
        logic busy;
    } seq_status_t;

endpackage

// File: sv/pwrf_in_if.sv
// Request channel: one tick with a start flag and a code word.
// Depends on pwrf_pkg.
`timescale 1ns / 1ps

interface pwrf_in_if;
    logic                           valid;
    logic                           ready;
    logic                           start_request;
    logic [pwrf_pkg::CODE_BITS-1:0] code_word;

    modport source (output valid, output start_request, output code_word, input ready);
    modport sink (input valid, input start_request, input code_word, output ready);
endinterface

// File: sv/pwrf_out_if.sv
// Result channel: line level, busy and done flags for one tick.
// No dependencies.
`timescale 1ns / 1ps

interface pwrf_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic done_res;

    modport source (output valid, output line_level, output busy_res, output done_res,
                    input ready);
    modport sink (input valid, input line_level, input busy_res, input done_res,
                  output ready);
endinterface

// File: sv/pwrf_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pwrf_pkg.
`timescale 1ns / 1ps

interface pwrf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pwrf_pkg::CFG_INDEX_W-1:0] index;
    logic [pwrf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/pwrf_cfg_regs.sv
// Configuration registers: pulse lengths, gap length, repeat count.
// Depends on pwrf_pkg and pwrf_cfg_if.
`timescale 1ns / 1ps

module pwrf_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    pwrf_cfg_if.sink       cfg,
    output pwrf_pkg::cfg_t regs
);
    import pwrf_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.short_ticks  <= SHORT_RESET;
            regs_reg.long_ticks   <= LONG_RESET;
            regs_reg.gap_ticks    <= GAP_RESET;
            regs_reg.repeat_count <= REPEAT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SHORT:  regs_reg.short_ticks  <= cfg.data[PULSE_W-1:0];
                REG_LONG:   regs_reg.long_ticks   <= cfg.data[PULSE_W-1:0];
                REG_GAP:    regs_reg.gap_ticks    <= cfg.data[GAP_W-1:0];
                REG_REPEAT: regs_reg.repeat_count <= cfg.data[REP_W-1:0];
                default:    ;
            endcase
        end
    end

endmodule

// File: sv/pwrf_seq.sv
// Frame sequencer: phase, timer, bit index and repeat state; one tick per request.
// Depends on pwrf_pkg.
`timescale 1ns / 1ps

module pwrf_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  logic                           start_request,
    input  logic [pwrf_pkg::CODE_BITS-1:0] code_word,
    input  pwrf_pkg::cfg_t                 regs,
    output pwrf_pkg::res_t                 res,
    output pwrf_pkg::seq_status_t          status
);
    import pwrf_pkg::*;

    phase_t                 phase_reg, phase_next, ph_e;
    logic [TIMER_W-1:0]     timer_reg, timer_next, timer_e, timer_inc;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next, bit_e;
    logic [REP_W-1:0]       reps_reg, reps_next, reps_e, reps_dec;
    logic [CODE_BITS-1:0]   code_reg, code_e;
    logic                   cur_bit;
    logic                   done;
    logic [TIMER_W-1:0]     short_len, long_len, gap_len, len;

    always_comb
    begin
        ph_e    = phase_reg;
        timer_e = timer_reg;
        bit_e   = bit_reg;
        reps_e  = reps_reg;
        code_e  = code_reg;
        // start is taken on the same tick it arrives
        if (phase_reg == PH_IDLE && start_request)
        begin
            ph_e    = PH_START_HIGH;
            timer_e = '0;
            bit_e   = '0;
            reps_e  = (regs.repeat_count == '0) ? REP_W'(1) : regs.repeat_count;
            code_e  = code_word;
        end

        cur_bit   = code_e[BIT_IDX_W'(CODE_BITS - 1) - bit_e];
        short_len = (regs.short_ticks == '0) ? TIMER_W'(1) : TIMER_W'(regs.short_ticks);
        long_len  = (regs.long_ticks == '0) ? TIMER_W'(1) : TIMER_W'(regs.long_ticks);
        gap_len   = (regs.gap_ticks == '0) ? TIMER_W'(1) : TIMER_W'(regs.gap_ticks);

        case (ph_e)
            PH_START_HIGH: len = short_len;
            PH_START_LOW:  len = long_len;
            PH_BIT_HIGH:   len = cur_bit ? long_len : short_len;
            PH_BIT_LOW:    len = cur_bit ? short_len : long_len;
            PH_GAP:        len = gap_len;
            default:       len = TIMER_W'(1);
        endcase

        timer_inc  = timer_e + TIMER_W'(1);
        reps_dec   = reps_e - REP_W'(1);
        phase_next = ph_e;
        timer_next = timer_e;
        bit_next   = bit_e;
        reps_next  = reps_e;
        done       = 1'b0;

        if (ph_e != PH_IDLE)
        begin
            timer_next = timer_inc;
            if (timer_inc >= len)
            begin
                timer_next = '0;
                case (ph_e)
                    PH_START_HIGH:
                    begin
                        phase_next = PH_START_LOW;
                    end
                    PH_START_LOW:
                    begin
                        phase_next = PH_BIT_HIGH;
                        bit_next   = '0;
                    end
                    PH_BIT_HIGH:
                    begin
                        phase_next = PH_BIT_LOW;
                    end
                    PH_BIT_LOW:
                    begin
                        if (bit_e != BIT_IDX_W'(CODE_BITS - 1))
                        begin
                            bit_next   = bit_e + BIT_IDX_W'(1);
                            phase_next = PH_BIT_HIGH;
                        end
                        else if (regs.gap_ticks == '0)
                        begin
                            // no gap: frame ends on its last low tick
                            reps_next  = reps_dec;
                            bit_next   = '0;
                            done       = (reps_dec == '0);
                            phase_next = (reps_dec == '0) ? PH_IDLE : PH_START_HIGH;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                    default:
                    begin
                        reps_next  = reps_dec;
                        bit_next   = '0;
                        done       = (reps_dec == '0);
                        phase_next = (reps_dec == '0) ? PH_IDLE : PH_START_HIGH;
                    end
                endcase
            end
        end

        res.line_level = (ph_e == PH_START_HIGH) || (ph_e == PH_BIT_HIGH);
        res.busy_res   = (ph_e != PH_IDLE);
        res.done_res   = done;
        status.busy    = (phase_reg != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            reps_reg  <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            reps_reg  <= reps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            code_reg <= code_e;
        end
    end

endmodule

// File: sv/pwrf_out_stage.sv
// Two-entry output buffer (result register plus skid) for the result channel.
// Depends on pwrf_pkg and pwrf_out_if.
`timescale 1ns / 1ps

module pwrf_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwrf_pkg::res_t data,
    output logic           can_push,
    pwrf_out_if.source     res_out
);
    import pwrf_pkg::*;

    logic main_valid_reg, skid_valid_reg;
    res_t main_data_reg, skid_data_reg;
    logic pop;

    assign can_push           = !skid_valid_reg;
    assign pop                = main_valid_reg && res_out.ready;
    assign res_out.valid      = main_valid_reg;
    assign res_out.line_level = main_data_reg.line_level;
    assign res_out.busy_res   = main_data_reg.busy_res;
    assign res_out.done_res   = main_data_reg.done_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : data;
        end
        else if (push)
        begin
            skid_data_reg <= data;
        end
    end

endmodule

// File: sv/pulse_width_rf_code_sender.sv
// Pulse-width OOK code sender. The result of an accepted tick request is registered
// in the output buffer; one request per cycle is sustained while the buffer has
// room, as the sequencer updates once per accepted tick. The buffer holds two
// results, so one request is still taken while a result stalls. Reset clears the
// sequencer to idle and loads the register defaults: short 300, long 900, gap 10000, repeat 6.
`timescale 1ns / 1ps
`include "pulse_width_rf_code_sender_defines.svh"

module pulse_width_rf_code_sender (
    input  logic        clk,
    input  logic        rst_n,
    pwrf_in_if.sink     req_in,
    pwrf_out_if.source  res_out,
    pwrf_cfg_if.sink    cfg
);
    import pwrf_pkg::*;

    cfg_t        regs;
    res_t        res;
    seq_status_t status;
    logic        can_push;
    logic        tick;

    assign req_in.ready = can_push;
    assign tick         = req_in.valid && can_push;

    pwrf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pwrf_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .start_request (req_in.start_request),
        .code_word     (req_in.code_word),
        .regs          (regs),
        .res           (res),
        .status        (status)
    );

    pwrf_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (tick),
        .data     (res),
        .can_push (can_push),
        .res_out  (res_out)
    );

    `PWRF_ASSERT_IMPL(a_done_while_busy, res_out.valid && res_out.done_res, res_out.busy_res, "done without busy")
    `PWRF_ASSERT_IMPL(a_stall_has_result, !req_in.ready, res_out.valid, "request stalled with no result held")
    `PWRF_ASSERT_NEXT(a_start_goes_busy, tick && !status.busy && req_in.start_request, status.busy, "start did not launch a sequence")

endmodule
